>>> src/imutilt_pkg.sv
package imutilt_pkg;

  // vectoring cordic iterations, capped by the arctangent table
  localparam int CORDIC_STEPS = 16;
  localparam int ATAN_LEN     = 24;
  localparam int STEPS_EFF    = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;
  localparam int STEP_W       = (STEPS_EFF > 1) ? $clog2(STEPS_EFF) : 1;
  localparam int ATAN_IW      = $clog2(ATAN_LEN);

  // restoring divider: one quotient bit per cycle over a 31-bit numerator
  localparam int DIV_STEPS = 31;
  localparam int DIV_CW    = $clog2(DIV_STEPS);

  localparam logic [14:0] ANGLE_LIMIT = 15'd11520;

  // reset values of the divisor registers
  localparam logic [15:0] ACCEL_XY_RST = 16'd16384;
  localparam logic [15:0] ACCEL_Z_RST  = 16'd14418;
  localparam logic [15:0] GYRO_RST     = 16'd131;

  // atan(2^-i) in units of 1/32768 degree
  localparam logic [20:0] ATAN_LUT [ATAN_LEN] = '{
    21'd1474560, 21'd870484, 21'd459940, 21'd233473, 21'd117189, 21'd58652,
    21'd29333, 21'd14667, 21'd7334, 21'd3667, 21'd1833, 21'd917,
    21'd458, 21'd229, 21'd115, 21'd57, 21'd29, 21'd14,
    21'd7, 21'd4, 21'd2, 21'd1, 21'd0, 21'd0
  };

  typedef enum logic [1:0] {
    CFG_ACCEL_XY = 2'd0,
    CFG_ACCEL_Z  = 2'd1,
    CFG_GYRO     = 2'd2
  } cfg_idx_t;

  // classified frame: per lane numerator 2*|raw|*mult + d, divisor 2*d, sign
  typedef struct packed {
    logic [5:0][30:0] num;
    logic [5:0][16:0] den;
    logic [5:0]       neg;
  } job_t;

  typedef struct packed {
    logic [29:0] g_x;
    logic [29:0] g_y;
    logic [29:0] g_z;
    logic [22:0] rate_x;
    logic [22:0] rate_y;
    logic [22:0] rate_z;
    logic [14:0] pitch_deg;
    logic [14:0] roll_deg;
  } result_t;

  typedef struct packed {
    logic        start;
    logic [29:0] y;
    logic [29:0] a;
    logic [29:0] b;
  } tilt_req_t;

  typedef struct packed {
    logic        done;
    logic [14:0] angle;
  } tilt_rsp_t;

endpackage

>>> src/imutilt_front.sv
module imutilt_front import imutilt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_accel_x,
  input  logic [15:0] in_accel_y,
  input  logic [15:0] in_accel_z,
  input  logic [15:0] in_gyro_x,
  input  logic [15:0] in_gyro_y,
  input  logic [15:0] in_gyro_z,
  output logic        job_valid,
  input  logic        job_pop,
  output job_t        job
);

  logic [15:0] div_xy_r, div_z_r, div_g_r;
  job_t        q_r [2];
  logic        head_r, tail_r;
  logic [1:0]  count_r;
  job_t        job_nxt;
  logic        push;

  // divisor registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_xy_r <= ACCEL_XY_RST;
      div_z_r  <= ACCEL_Z_RST;
      div_g_r  <= GYRO_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_ACCEL_XY: div_xy_r <= cfg_data;
        CFG_ACCEL_Z:  div_z_r  <= cfg_data;
        CFG_GYRO:     div_g_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // classify each axis into magnitude numerator, divisor and sign
  always_comb begin
    logic [15:0] raw [6];
    logic [15:0] d   [6];
    logic [16:0] mag;
    raw[0] = in_accel_x; raw[1] = in_accel_y; raw[2] = in_accel_z;
    raw[3] = in_gyro_x;  raw[4] = in_gyro_y;  raw[5] = in_gyro_z;
    d[0] = div_xy_r; d[1] = div_xy_r; d[2] = div_z_r;
    d[3] = div_g_r;  d[4] = div_g_r;  d[5] = div_g_r;
    job_nxt = '0;
    for (int k = 0; k < 6; k++) begin
      // a zero divisor acts as one
      if (d[k] == 16'd0) d[k] = 16'd1;
      mag = raw[k][15] ? (~{1'b1, raw[k]}) + 17'd1 : {1'b0, raw[k]};
      job_nxt.neg[k] = raw[k][15];
      job_nxt.den[k] = {d[k], 1'b0};
      if (k < 3)
        job_nxt.num[k] = 31'({mag, 15'b0}) + 31'(d[k]);
      else
        job_nxt.num[k] = 31'({mag, 8'b0}) + 31'(d[k]);
    end
  end

  // two-word queue towards the back end
  assign push      = in_push && !in_full;
  assign in_full   = (count_r == 2'd2);
  assign job_valid = (count_r != 2'd0);
  assign job       = q_r[head_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= 1'b0;
      tail_r  <= 1'b0;
      count_r <= 2'd0;
    end else begin
      if (push) tail_r <= ~tail_r;
      if (job_pop) head_r <= ~head_r;
      count_r <= count_r + 2'(push) - 2'(job_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[tail_r] <= job_nxt;
  end

endmodule

>>> src/imutilt_tilt.sv
module imutilt_tilt import imutilt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  tilt_req_t req,
  output tilt_rsp_t rsp
);

  typedef enum logic [7:0] {
    T_IDLE = 8'b0000_0001,
    T_SQ   = 8'b0000_0010,
    T_SUM  = 8'b0000_0100,
    T_ROOT = 8'b0000_1000,
    T_NORM = 8'b0001_0000,
    T_ROT  = 8'b0010_0000,
    T_FIN  = 8'b0100_0000,
    T_DONE = 8'b1000_0000
  } tstate_t;

  tstate_t            state_r;
  logic               yneg_r;
  logic [29:0]        ua_r, ub_r, my_r;
  logic [59:0]        pa_r, pb_r;
  logic [60:0]        n_r, r_r, bit_r;
  logic signed [34:0] x_r, y_r;
  logic signed [23:0] z_r;
  logic [STEP_W-1:0]  i_r;
  logic [14:0]        angle_r;

  logic [60:0]        trial;
  logic [34:0]        big;
  logic signed [34:0] xs, ys;
  logic signed [23:0] zc, lut;
  logic [16:0]        rnd;

  assign rsp.done  = (state_r == T_DONE);
  assign rsp.angle = angle_r;

  always_comb begin
    trial = r_r + bit_r;
    big   = (x_r > y_r) ? x_r : y_r;
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    lut   = 24'(ATAN_LUT[ATAN_IW'(i_r)]);
    zc    = z_r[23] ? 24'sd0 : z_r;
    rnd   = 17'((25'(zc) + 25'd128) >> 8);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= T_IDLE;
    end else begin
      unique case (state_r)
        T_IDLE, T_DONE: if (req.start) state_r <= T_SQ;
        T_SQ:   state_r <= T_SUM;
        T_SUM:  state_r <= T_ROOT;
        T_ROOT: if (bit_r[0]) state_r <= T_NORM;
        T_NORM: begin
          if (x_r == 35'sd0 && y_r == 35'sd0) state_r <= T_FIN;
          else if (big >= 35'(1 << 30)) state_r <= T_ROT;
        end
        T_ROT:  if (i_r == STEP_W'(STEPS_EFF - 1)) state_r <= T_FIN;
        T_FIN:  state_r <= T_DONE;
        default: state_r <= T_IDLE;
      endcase
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      T_IDLE, T_DONE: begin
        // magnitudes of the three scaled axes
        if (req.start) begin
          yneg_r <= req.y[29];
          my_r   <= req.y[29] ? 30'(-req.y) : req.y;
          ua_r   <= req.a[29] ? 30'(-req.a) : req.a;
          ub_r   <= req.b[29] ? 30'(-req.b) : req.b;
        end
      end
      T_SQ: begin
        pa_r <= ua_r * ua_r;
        pb_r <= ub_r * ub_r;
      end
      T_SUM: begin
        n_r   <= 61'(pa_r) + 61'(pb_r);
        r_r   <= '0;
        bit_r <= 61'(1) << 60;
      end
      T_ROOT: begin
        // one result bit of the floor square root per cycle
        if (n_r >= trial) begin
          n_r <= n_r - trial;
          r_r <= (r_r >> 1) + bit_r;
        end else begin
          r_r <= r_r >> 1;
        end
        bit_r <= bit_r >> 2;
        if (bit_r[0]) begin
          x_r <= 35'(r_r[30:0] >> 1) + 35'(n_r >= trial);
          y_r <= 35'(my_r);
        end
      end
      T_NORM: begin
        // shift both up together until the larger reaches 2^30
        if (big < 35'(1 << 26)) begin
          x_r <= x_r <<< 4;
          y_r <= y_r <<< 4;
        end else if (big < 35'(1 << 30)) begin
          x_r <= x_r <<< 1;
          y_r <= y_r <<< 1;
        end
        z_r <= '0;
        i_r <= '0;
      end
      T_ROT: begin
        if (!y_r[34]) begin
          x_r <= x_r + ys;
          y_r <= y_r - xs;
          z_r <= z_r + lut;
        end else begin
          x_r <= x_r - ys;
          y_r <= y_r + xs;
          z_r <= z_r - lut;
        end
        i_r <= i_r + STEP_W'(1);
      end
      T_FIN: begin
        // round to 1/128 degree, clamp, then apply the sign of y
        if (rnd > 17'(ANGLE_LIMIT))
          angle_r <= yneg_r ? 15'(-ANGLE_LIMIT) : ANGLE_LIMIT;
        else
          angle_r <= yneg_r ? 15'(-rnd) : rnd[14:0];
      end
      default: ;
    endcase
  end

endmodule

>>> src/imutilt_back.sv
module imutilt_back import imutilt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        job_valid,
  output logic        job_pop,
  input  job_t        job,
  output logic        out_empty,
  input  logic        out_pop,
  output result_t     res
);

  typedef enum logic [5:0] {
    S_IDLE   = 6'b00_0001,
    S_DIV    = 6'b00_0010,
    S_SCALE  = 6'b00_0100,
    S_LAUNCH = 6'b00_1000,
    S_TILT   = 6'b01_0000,
    S_STORE  = 6'b10_0000
  } bstate_t;

  bstate_t          state_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [5:0][30:0] num_r, num_nxt;
  logic [5:0][16:0] den_r;
  logic [5:0][16:0] rem_r, rem_nxt;
  logic [5:0]       neg_r;
  result_t          cur_r;
  tilt_req_t        pitch_req, roll_req;
  tilt_rsp_t        pitch_rsp, roll_rsp;

  result_t          oq_r [2];
  logic             ohead_r, otail_r;
  logic [1:0]       ocount_r;
  logic             opush;

  assign job_pop = (state_r == S_IDLE) && job_valid;
  assign opush   = (state_r == S_STORE) && (ocount_r != 2'd2);

  // six restoring divider lanes, one quotient bit each per cycle
  always_comb begin
    logic [17:0] sh;
    for (int k = 0; k < 6; k++) begin
      sh = {rem_r[k], num_r[k][30]};
      if (sh >= 18'(den_r[k])) begin
        rem_nxt[k] = 17'(sh - 18'(den_r[k]));
        num_nxt[k] = {num_r[k][29:0], 1'b1};
      end else begin
        rem_nxt[k] = sh[16:0];
        num_nxt[k] = {num_r[k][29:0], 1'b0};
      end
    end
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      unique case (state_r)
        S_IDLE:   if (job_valid) state_r <= S_DIV;
        S_DIV:    if (cnt_r == DIV_CW'(DIV_STEPS - 1)) state_r <= S_SCALE;
        S_SCALE:  state_r <= S_LAUNCH;
        S_LAUNCH: state_r <= S_TILT;
        S_TILT:   if (pitch_rsp.done && roll_rsp.done) state_r <= S_STORE;
        S_STORE:  if (opush) state_r <= S_IDLE;
        default:  state_r <= S_IDLE;
      endcase
    end
  end

  // divider and result assembly
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        num_r <= job.num;
        den_r <= job.den;
        neg_r <= job.neg;
        rem_r <= '0;
        cnt_r <= '0;
      end
      S_DIV: begin
        num_r <= num_nxt;
        rem_r <= rem_nxt;
        cnt_r <= cnt_r + DIV_CW'(1);
      end
      S_SCALE: begin
        cur_r.g_x    <= neg_r[0] ? 30'(-num_r[0]) : num_r[0][29:0];
        cur_r.g_y    <= neg_r[1] ? 30'(-num_r[1]) : num_r[1][29:0];
        cur_r.g_z    <= neg_r[2] ? 30'(-num_r[2]) : num_r[2][29:0];
        cur_r.rate_x <= neg_r[3] ? 23'(-num_r[3]) : num_r[3][22:0];
        cur_r.rate_y <= neg_r[4] ? 23'(-num_r[4]) : num_r[4][22:0];
        cur_r.rate_z <= neg_r[5] ? 23'(-num_r[5]) : num_r[5][22:0];
      end
      S_TILT: begin
        cur_r.pitch_deg <= pitch_rsp.angle;
        cur_r.roll_deg  <= roll_rsp.angle;
      end
      default: ;
    endcase
  end

  // pitch from y over x,z and roll from x over y,z
  always_comb begin
    pitch_req.start = (state_r == S_LAUNCH);
    pitch_req.y     = cur_r.g_y;
    pitch_req.a     = cur_r.g_x;
    pitch_req.b     = cur_r.g_z;
    roll_req.start  = (state_r == S_LAUNCH);
    roll_req.y      = cur_r.g_x;
    roll_req.a      = cur_r.g_y;
    roll_req.b      = cur_r.g_z;
  end

  imutilt_tilt u_pitch (.clk(clk), .rst_n(rst_n), .req(pitch_req), .rsp(pitch_rsp));
  imutilt_tilt u_roll  (.clk(clk), .rst_n(rst_n), .req(roll_req),  .rsp(roll_rsp));

  // two-word result queue
  assign out_empty = (ocount_r == 2'd0);
  assign res       = oq_r[ohead_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ohead_r  <= 1'b0;
      otail_r  <= 1'b0;
      ocount_r <= 2'd0;
    end else begin
      if (opush) otail_r <= ~otail_r;
      if (out_pop && !out_empty) ohead_r <= ~ohead_r;
      ocount_r <= ocount_r + 2'(opush) - 2'(out_pop && !out_empty);
    end
  end

  always_ff @(posedge clk) begin
    if (opush) oq_r[otail_r] <= cur_r;
  end

endmodule

>>> src/imu_scale_and_tilt_angles_unit.sv
// channel   | handshake          | words
// ----------+--------------------+------------------------------------------
// in_       | in_push / in_full  | raw accel x,y,z and gyro x,y,z, 16b signed
// out_      | out_pop / out_empty| g x,y,z, rates x,y,z, pitch, roll
// cfg_      | cfg_we             | divisor index and 16b value
//
// one frame holds the back end through the bit-serial dividers, the scaling,
// the square root, the normalising shifts and the cordic steps (the shifts and
// cordic steps are skipped when all three g axes are zero), one frame at a time
// a two-word queue on each side accepts frames and holds results meanwhile
// reset is synchronous, active low; divisors return to 16384, 14418 and 131
// in_full rises only when both input words are taken; out_pop may stall freely
module imu_scale_and_tilt_angles_unit import imutilt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_push,
  output logic        in_full,
  input  logic [15:0] in_accel_x,
  input  logic [15:0] in_accel_y,
  input  logic [15:0] in_accel_z,
  input  logic [15:0] in_gyro_x,
  input  logic [15:0] in_gyro_y,
  input  logic [15:0] in_gyro_z,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [29:0] out_g_x,
  output logic [29:0] out_g_y,
  output logic [29:0] out_g_z,
  output logic [22:0] out_rate_x,
  output logic [22:0] out_rate_y,
  output logic [22:0] out_rate_z,
  output logic [14:0] out_pitch_deg,
  output logic [14:0] out_roll_deg
);

  logic    job_valid, job_pop;
  job_t    job;
  result_t res;

  // front: divisor registers, classification and job queue
  imutilt_front u_front (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_push(in_push), .in_full(in_full),
    .in_accel_x(in_accel_x), .in_accel_y(in_accel_y), .in_accel_z(in_accel_z),
    .in_gyro_x(in_gyro_x), .in_gyro_y(in_gyro_y), .in_gyro_z(in_gyro_z),
    .job_valid(job_valid), .job_pop(job_pop), .job(job)
  );

  // back: dividers, tilt engines and result queue
  imutilt_back u_back (
    .clk(clk), .rst_n(rst_n),
    .job_valid(job_valid), .job_pop(job_pop), .job(job),
    .out_empty(out_empty), .out_pop(out_pop), .res(res)
  );

  assign out_g_x       = res.g_x;
  assign out_g_y       = res.g_y;
  assign out_g_z       = res.g_z;
  assign out_rate_x    = res.rate_x;
  assign out_rate_y    = res.rate_y;
  assign out_rate_z    = res.rate_z;
  assign out_pitch_deg = res.pitch_deg;
  assign out_roll_deg  = res.roll_deg;

endmodule

>>> tb/sv/imu_scale_and_tilt_angles_unit_tb.sv
module imu_scale_and_tilt_angles_unit_tb;
  import imutilt_pkg::*;

  localparam logic [1:0] CFG_SPARE = 2'd3;  // no register behind this index
  localparam int RANDOM_FRAMES = 950;
  localparam int DRAIN_CYCLES = 150;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [15:0] in_accel_x = '0, in_accel_y = '0, in_accel_z = '0;
  logic [15:0] in_gyro_x = '0, in_gyro_y = '0, in_gyro_z = '0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  result_t     got;

  imu_scale_and_tilt_angles_unit DUT (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_push, .in_full, .in_accel_x, .in_accel_y, .in_accel_z,
    .in_gyro_x, .in_gyro_y, .in_gyro_z,
    .out_empty, .out_pop,
    .out_g_x(got.g_x), .out_g_y(got.g_y), .out_g_z(got.g_z),
    .out_rate_x(got.rate_x), .out_rate_y(got.rate_y), .out_rate_z(got.rate_z),
    .out_pitch_deg(got.pitch_deg), .out_roll_deg(got.roll_deg)
  );

  always #10 clk = ~clk;

  // predictor copy of the divisor registers
  logic [15:0] xy_div, z_div, gyro_div;

  result_t frame_results_q[$];
  int errors = 0;
  int frames_sent = 0;
  int words_checked = 0;
  int cfg_writes = 0;

  // atan(2^-i) in 1/32768 degree
  localparam longint ARCTAN_DEG [24] = '{
    1474560, 870484, 459940, 233473, 117189, 58652, 29333, 14667,
    7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0, 0
  };

  // raw * mult / div, rounded to nearest with ties away from zero
  function automatic longint scaled(logic [15:0] raw_bits, longint mult, logic [15:0] dv);
    longint raw, d, mag, q;
    raw = longint'($signed(raw_bits));
    d = (dv == 0) ? 1 : longint'(dv);
    mag = (raw < 0 ? -raw : raw) * mult;
    q = (2 * mag + d) / (2 * d);
    return (raw < 0) ? -q : q;
  endfunction

  function automatic longint floor_sqrt(longint unsigned n);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > n) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (n >= r + bitv) begin
        n = n - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return longint'(r);
  endfunction

  // atan2(y, sqrt(a^2 + b^2)) in 1/128 degree
  function automatic longint tilt_angle(longint y, longint a, longint b);
    longint mag, my, big, x, yy, z, r, xs, ys;
    mag = floor_sqrt(longint'(a * a + b * b));
    my = (y < 0) ? -y : y;
    z = 0;
    if (mag == 0 && my == 0) return 0;
    big = (mag > my) ? mag : my;
    while (big < (longint'(1) << 30)) begin
      big = big <<< 1;
      mag = mag <<< 1;
      my = my <<< 1;
    end
    x = mag;
    yy = my;
    for (int i = 0; i < STEPS_EFF; i++) begin
      xs = x >>> i;
      ys = yy >>> i;
      if (yy >= 0) begin
        x += ys; yy -= xs; z += ARCTAN_DEG[i];
      end else begin
        x -= ys; yy += xs; z -= ARCTAN_DEG[i];
      end
    end
    if (z < 0) z = 0;
    r = (z + 128) >>> 8;
    if (r > longint'(ANGLE_LIMIT)) r = longint'(ANGLE_LIMIT);
    return (y < 0) ? -r : r;
  endfunction

  function automatic result_t predict_frame(logic [15:0] raw [6]);
    result_t res;
    longint gx, gy, gz;
    gx = scaled(raw[0], 16384, xy_div);
    gy = scaled(raw[1], 16384, xy_div);
    gz = scaled(raw[2], 16384, z_div);
    res.g_x = gx[29:0];
    res.g_y = gy[29:0];
    res.g_z = gz[29:0];
    res.rate_x = 23'(scaled(raw[3], 128, gyro_div));
    res.rate_y = 23'(scaled(raw[4], 128, gyro_div));
    res.rate_z = 23'(scaled(raw[5], 128, gyro_div));
    res.pitch_deg = 15'(tilt_angle(gy, gx, gz));
    res.roll_deg = 15'(tilt_angle(gx, gy, gz));
    return res;
  endfunction

  task automatic flag(string field, logic [29:0] want, logic [29:0] have);
    errors++;
    if (errors <= 10)
      $display("mismatch on %s (word %0d): expected %h, got %h", field, words_checked, want, have);
  endtask

  // receiver: stall pattern changes mode every so often
  int pop_mode = 0;
  int pop_count = 0;
  always @(posedge clk) begin
    result_t want;
    if (out_pop && !out_empty) begin
      if (frame_results_q.size() == 0) begin
        flag("unexpected word", '0, got.g_x);
      end else begin
        want = frame_results_q.pop_front();
        if (got.g_x !== want.g_x) flag("g_x", want.g_x, got.g_x);
        if (got.g_y !== want.g_y) flag("g_y", want.g_y, got.g_y);
        if (got.g_z !== want.g_z) flag("g_z", want.g_z, got.g_z);
        if (got.rate_x !== want.rate_x) flag("rate_x", want.rate_x, got.rate_x);
        if (got.rate_y !== want.rate_y) flag("rate_y", want.rate_y, got.rate_y);
        if (got.rate_z !== want.rate_z) flag("rate_z", want.rate_z, got.rate_z);
        if (got.pitch_deg !== want.pitch_deg) flag("pitch_deg", want.pitch_deg, got.pitch_deg);
        if (got.roll_deg !== want.roll_deg) flag("roll_deg", want.roll_deg, got.roll_deg);
      end
      words_checked++;
    end
    pop_count++;
    if (pop_count % 300 == 0) pop_mode = $urandom_range(0, 2);
    case (pop_mode)
      0: out_pop <= 1'b1;
      1: out_pop <= ($urandom_range(0, 1) == 1);
      default: out_pop <= ($urandom_range(0, 15) == 0);
    endcase
  end

  // sender burst state
  int burst_left = 0;

  task automatic send_frame(logic [15:0] raw [6], bit typed, result_t typed_res);
    in_push <= 1'b1;
    in_accel_x <= raw[0]; in_accel_y <= raw[1]; in_accel_z <= raw[2];
    in_gyro_x <= raw[3]; in_gyro_y <= raw[4]; in_gyro_z <= raw[5];
    do @(posedge clk); while (in_full);
    frame_results_q.push_back(typed ? typed_res : predict_frame(raw));
    frames_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 12);
      if ($urandom_range(0, 3) != 0) begin
        in_push <= 1'b0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  // divisor write, only once every frame has come back
  task automatic write_divisor(logic [1:0] idx, logic [15:0] val);
    in_push <= 1'b0;
    @(posedge clk);
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_ACCEL_XY: xy_div = val;
      CFG_ACCEL_Z: z_div = val;
      CFG_GYRO: gyro_div = val;
      default: ;
    endcase
    cfg_writes++;
  endtask

  function automatic logic [15:0] random_axis(int style);
    case (style)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(0, 1200)) - 600);
      default: return 16'($signed($urandom_range(0, 36000)) - 18000);
    endcase
  endfunction

  typedef struct {
    logic [15:0] raw [6];
    bit          typed;
    result_t     want;
  } stim_row_t;

  function automatic stim_row_t row(int ax, int ay, int az, int gx, int gy, int gz);
    stim_row_t r;
    r.raw = '{16'(ax), 16'(ay), 16'(az), 16'(gx), 16'(gy), 16'(gz)};
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  initial begin
    stim_row_t rows[$];
    stim_row_t r;
    logic [15:0] raw [6];
    logic [15:0] extremes [4];
    int style;

    extremes = '{16'd1, 16'd65535, 16'd0, 16'd65535};
    xy_div = ACCEL_XY_RST;
    z_div = ACCEL_Z_RST;
    gyro_div = GYRO_RST;

    // directed frames under the reset divisors
    r = row(0, 0, 0, 0, 0, 0); r.typed = 1'b1;  // all-zero frame gives zero angles
    rows.push_back(r);
    r = row(0, 0, 0, 131, -131, 262); r.typed = 1'b1;
    r.want.rate_x = 23'sd128; r.want.rate_y = -23'sd128; r.want.rate_z = 23'sd256;
    rows.push_back(r);
    rows.push_back(row(16384, -16384, 0, 0, 0, 0));  // 45 degree pair via predictor
    rows.push_back(row(32767, 32767, 32767, 32767, 32767, 32767));
    rows.push_back(row(-32768, -32768, -32768, -32768, -32768, -32768));
    rows.push_back(row(32767, -32768, 0, -32768, 32767, 0));
    rows.push_back(row(0, 0, 14418, 0, 0, 0));
    rows.push_back(row(0, 0, -32768, 0, 0, 0));
    rows.push_back(row(32767, 0, 0, 0, 0, 0));
    rows.push_back(row(0, -32768, 0, 0, 0, 0));
    rows.push_back(row(1, -1, 1, 1, -1, 65));
    rows.push_back(row(-1, 1, 0, 66, -65, -66));
    rows.push_back(row(8192, 8192, 11585, 100, 200, 300));
    rows.push_back(row(-12000, 5000, -9000, -1000, 1000, 0));
    rows.push_back(row(0, 1, 0, 0, 0, 0));

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) send_frame(rows[i].raw, rows[i].typed, rows[i].want);

    // extreme divisors, zero divisor and a write to the spare index
    for (int p = 0; p < 10; p++) begin
      if (p < 4) begin
        write_divisor(CFG_ACCEL_XY, extremes[p]);
        write_divisor(CFG_ACCEL_Z, extremes[(p + 1) % 4]);
        write_divisor(CFG_GYRO, extremes[(p + 2) % 4]);
      end else begin
        write_divisor(CFG_ACCEL_XY, 16'($urandom_range(1, 65535)));
        write_divisor(CFG_ACCEL_Z, ($urandom_range(0, 1) == 1) ? 16'($urandom) :
                                   16'($urandom_range(1, 300)));
        write_divisor(CFG_GYRO, 16'($urandom_range(0, 400)));
      end
      if (p == 5) write_divisor(CFG_SPARE, 16'($urandom));
      for (int k = 0; k < RANDOM_FRAMES / 10; k++) begin
        style = $urandom_range(0, 3);
        foreach (raw[j]) raw[j] = random_axis(style == 3 ? 0 : style);
        send_frame(raw, 1'b0, '0);
      end
    end

    // wait for every result, then a short drain
    in_push <= 1'b0;
    while (frame_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d frames and %0d result words over %0d divisor writes",
             frames_sent, words_checked, cfg_writes);
    $display("divisor settings included 1, 65535, zero and an unused index");
    if (errors == 0 && frame_results_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #80000000;
    $display("timeout with %0d words outstanding", frame_results_q.size());
    $display("TEST FAILED");
    $finish;
  end

endmodule

>>> filelist.f
src/imutilt_pkg.sv
src/imutilt_front.sv
src/imutilt_tilt.sv
src/imutilt_back.sv
src/imu_scale_and_tilt_angles_unit.sv
tb/sv/imu_scale_and_tilt_angles_unit_tb.sv
